### hdl/assert_macros.svh
// Assertion macros shared by the decimal text converter modules.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold on every clock edge outside reset.
`define SITDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// A consequence that must hold in the clock cycle after its antecedent.
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SITDA_ASSERT(lbl, prop, msg)
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/sitda_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes, the payload types and the double-dabble helpers.
package sitda_pkg;

	localparam int VALUE_W        = 32;
	localparam int CHAR_W         = 8;
	localparam int MAX_DIGITS     = 10;
	localparam int DIGIT_W        = 4;
	localparam int BCD_W          = MAX_DIGITS * DIGIT_W;
	localparam int IDX_W          = $clog2(MAX_DIGITS);
	localparam int BITS_PER_STAGE = 4;
	localparam int NUM_DAB_STAGES = VALUE_W / BITS_PER_STAGE;

	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'd57;
	localparam logic [DIGIT_W-1:0] RADIX      = 4'd10;

	typedef struct packed {
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] mag;
	} dab_t;

	typedef struct packed {
		logic             neg;
		logic [BCD_W-1:0] bcd;
	} bcd_word_t;

	// One shift-and-add-three step of the binary to BCD conversion.
	function automatic dab_t dabble(input dab_t d);
		dab_t r;
		r = d;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (r.bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
				r.bcd[i*DIGIT_W +: DIGIT_W] = r.bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
			end
		end
		r = dab_t'({r.bcd, r.mag} << 1);
		return r;
	endfunction

	// Position of the most significant non-zero digit; zero when all digits are zero.
	function automatic logic [IDX_W-1:0] msd_index(input logic [BCD_W-1:0] bcd);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

	// True when every digit lies below the radix.
	function automatic logic bcd_ok(input logic [BCD_W-1:0] bcd);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd[i*DIGIT_W +: DIGIT_W] >= RADIX) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

### hdl/sitda_b2bcd.sv
// Pipelined binary to BCD converter: magnitude stage then double-dabble stages.
// Depends on sitda_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sitda_b2bcd (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sitda_pkg::VALUE_W-1:0] in_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output sitda_pkg::bcd_word_t                out_word
);
	import sitda_pkg::*;

	// Stage one: sign and magnitude.
	logic               valid_s1;
	logic               neg_s1;
	logic [VALUE_W-1:0] mag_s1;
	logic               ready_s1;

	// Dabble stages, each consuming BITS_PER_STAGE bits of the magnitude.
	logic dab_valid_s [NUM_DAB_STAGES];
	logic dab_neg_s   [NUM_DAB_STAGES];
	dab_t dab_word_s  [NUM_DAB_STAGES];
	logic dab_ready   [NUM_DAB_STAGES];

	assign in_ready = ready_s1;
	assign ready_s1 = !valid_s1 || dab_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			neg_s1 <= in_value[VALUE_W-1];
			mag_s1 <= in_value[VALUE_W-1] ? (~in_value) + VALUE_W'(1) : in_value;
		end
	end

	for (genvar s = 0; s < NUM_DAB_STAGES; s++) begin : g_dab
		logic prev_valid;
		logic prev_neg;
		dab_t prev_word;
		dab_t next_word;
		logic next_ready;

		if (s == 0) begin : g_first
			assign prev_valid = valid_s1;
			assign prev_neg   = neg_s1;
			assign prev_word  = '{bcd: '0, mag: mag_s1};
		end else begin : g_rest
			assign prev_valid = dab_valid_s[s-1];
			assign prev_neg   = dab_neg_s[s-1];
			assign prev_word  = dab_word_s[s-1];
		end

		if (s == NUM_DAB_STAGES - 1) begin : g_last
			assign next_ready = out_ready;
		end else begin : g_mid
			assign next_ready = dab_ready[s+1];
		end

		assign dab_ready[s] = !dab_valid_s[s] || next_ready;

		always_comb begin
			next_word = prev_word;
			for (int b = 0; b < BITS_PER_STAGE; b++) begin
				next_word = dabble(next_word);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dab_valid_s[s] <= 1'b0;
			end else if (dab_ready[s]) begin
				dab_valid_s[s] <= prev_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (dab_ready[s] && prev_valid) begin
				dab_neg_s[s]  <= prev_neg;
				dab_word_s[s] <= next_word;
			end
		end
	end

	assign out_valid    = dab_valid_s[NUM_DAB_STAGES-1];
	assign out_word.neg = dab_neg_s[NUM_DAB_STAGES-1];
	assign out_word.bcd = dab_word_s[NUM_DAB_STAGES-1].bcd;

	// Every magnitude bit must have been shifted into the digits by the last stage.
	`SITDA_ASSERT(a_mag_consumed, out_valid |-> dab_word_s[NUM_DAB_STAGES-1].mag == '0, "magnitude bits left after final stage")
	`SITDA_ASSERT(a_digits_legal, out_valid |-> bcd_ok(out_word.bcd), "BCD digit out of range")

endmodule

### hdl/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII text converter.
// Depends on sitda_pkg, sitda_b2bcd and assert_macros.svh.
//
// Each 32-bit signed value transferred in produces its decimal text, one
// character per output transfer: a '-' for negative values, then the digits
// most significant first with no leading zeros, zero giving "0", and
// last_char set on the final character. The most negative value converts
// exactly. The value first passes a nine-stage pipeline (one sign and
// magnitude stage, then eight double-dabble stages of four bits each), then
// the serialiser and the output register, before its first character
// appears. A new value may enter every cycle that item_ready is high, and
// the character output moves one character per cycle while char_ready is
// high, so a value occupies the serialiser while its characters go out, from
// one for a single digit up to eleven for a negative ten-digit value. The
// pipeline stages buffer values behind the serialiser, and back-pressure on
// the character channel holds every stage without losing or repeating anything.
`include "assert_macros.svh"

module signed_int_to_decimal_ascii (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic signed [sitda_pkg::VALUE_W-1:0] value,
	output logic                                 char_valid,
	input  logic                                 char_ready,
	output logic [sitda_pkg::CHAR_W-1:0]         character,
	output logic                                 last_char
);
	import sitda_pkg::*;

	logic             pipe_valid;
	logic             pipe_ready;
	bcd_word_t        pipe_word;

	// Serialiser state: the digits of the value being spelt out, a pending
	// minus sign and the position of the next digit to send.
	logic             busy_q;
	logic             neg_q;
	logic [IDX_W-1:0] idx_q;
	logic [BCD_W-1:0] bcd_q;

	// Output register, which parts the serialiser from the character channel.
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;

	logic               slot_free;
	logic               emit;
	logic               ser_load;
	logic [DIGIT_W-1:0] cur_digit;

	sitda_b2bcd u_b2bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_ready  (item_ready),
		.in_value  (value),
		.out_valid (pipe_valid),
		.out_ready (pipe_ready),
		.out_word  (pipe_word)
	);

	// The output register can take a new character when it is empty or its
	// current character is being transferred in this cycle.
	assign slot_free = !out_valid_q || char_ready;
	assign emit      = busy_q && slot_free;

	// A new value may be loaded in the same cycle as the last digit of the
	// previous one leaves, so the serialiser never idles between values.
	assign pipe_ready = !busy_q || (slot_free && !neg_q && idx_q == '0);
	assign ser_load   = pipe_valid && pipe_ready;

	assign cur_digit = bcd_q[{idx_q, 2'b00} +: DIGIT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			neg_q  <= 1'b0;
			idx_q  <= '0;
		end else if (ser_load) begin
			busy_q <= 1'b1;
			neg_q  <= pipe_word.neg;
			idx_q  <= msd_index(pipe_word.bcd);
		end else if (emit) begin
			if (neg_q) begin
				neg_q <= 1'b0;
			end else if (idx_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load) begin
			bcd_q <= pipe_word.bcd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (neg_q) begin
				out_char_q <= CHAR_MINUS;
				out_last_q <= 1'b0;
			end else begin
				out_char_q <= CHAR_ZERO + CHAR_W'(cur_digit);
				out_last_q <= (idx_q == '0);
			end
		end
	end

	assign char_valid = out_valid_q;
	assign character  = out_char_q;
	assign last_char  = out_last_q;

	`SITDA_ASSERT(a_char_legal, char_valid |-> (character == CHAR_MINUS || (character >= CHAR_ZERO && character <= CHAR_NINE)), "illegal character code")
	`SITDA_ASSERT(a_minus_not_last, (char_valid && character == CHAR_MINUS) |-> !last_char, "minus sign marked as last character")
	`SITDA_ASSERT(a_idx_range, busy_q |-> idx_q < IDX_W'(MAX_DIGITS), "digit position beyond digit count")
	`SITDA_ASSERT_NEXT(a_load_busy, ser_load, busy_q, "serialiser idle after loading a value")

endmodule
